// ===== src/hcbd_pkg.sv =====
// Shared types and constants of the chunked body decoder.
package hcbd_pkg;

  // Parser phase of the body.
  typedef enum logic [3:0] {
    PH_SIZE     = 4'd0,
    PH_EXT      = 4'd1,
    PH_DATA     = 4'd2,
    PH_DATA_EOL = 4'd3,
    PH_TRAILER  = 4'd4,
    PH_DONE     = 4'd5,
    PH_ERROR    = 4'd6
  } phase_e;

  // Result kind reported for each input byte.
  typedef enum logic [2:0] {
    KIND_FRAME   = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_END     = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_IGNORED = 3'd4
  } kind_e;

  localparam int unsigned LimitW = 17;
  localparam int unsigned SizeW  = 64;

  localparam logic [LimitW-1:0] SizeLimitReset    = LimitW'(1024);
  localparam logic [LimitW-1:0] TrailerLimitReset = LimitW'(64 * 1024);

  localparam logic [7:0] ByteCr   = 8'h0D;
  localparam logic [7:0] ByteLf   = 8'h0A;
  localparam logic [7:0] ByteSemi = 8'h3B;

  // Register byte addresses.
  localparam logic [2:0] AddrSizeLimit    = 3'd0;
  localparam logic [2:0] AddrTrailerLimit = 3'd4;

  // Result of one decode step.
  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       chunk_last;
  } hcbd_res_t;

endpackage

// ===== src/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked body decoder.
//
// Raw body bytes enter on the s_axis stream, one byte per request. Every
// byte yields exactly one result request on m_axis: tdata carries the
// payload byte (zero unless the kind is payload), tuser the kind (framing,
// payload, end of body, error, ignored) and tlast marks the last payload
// byte of a chunk.
// A byte goes from input handshake to result valid through one input
// register, then the decode step into the result register. Throughput is
// one byte per cycle while the receiver does not stall; the size update,
// payload count and line-length check all finish in the single decode step.
// Reset clears the parser to the start of a size line and restores the line
// limits (size line 1024, trailer line 65536). Limits are written through the APB
// port at 0x0 and 0x4; the user must write them only while the stream is idle, as the block does not enforce it.
// When the receiver stalls, the result register holds, the decode step
// waits and one more byte is still taken into the input register; after
// that s_axis_tready drops until the result is taken.
// After an error or the end of body every further byte reports ignored
// until reset.
module http_chunked_body_decoder import hcbd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]  m_axis_tuser,   // [2:0] kind
  output logic        m_axis_tlast,   // chunk_last
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LimitW-1:0] size_lim_q, trl_lim_q;
  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  hcbd_res_t         out_q;
  hcbd_res_t         res;
  logic              out_free, step, in_acc, cfg_wr;

  // Register access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[2] ? {{(32-LimitW){1'b0}}, trl_lim_q}
                           : {{(32-LimitW){1'b0}}, size_lim_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_lim_q <= SizeLimitReset;
      trl_lim_q  <= TrailerLimitReset;
    end else if (cfg_wr) begin
      if (paddr[2] == AddrTrailerLimit[2]) begin
        trl_lim_q <= pwdata[LimitW-1:0];
      end else begin
        size_lim_q <= pwdata[LimitW-1:0];
      end
    end
  end

  // Stage control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || step;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_acc) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  hcbd_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .in_byte_i       (in_byte_q),
    .size_limit_i    (size_lim_q),
    .trailer_limit_i (trl_lim_q),
    .res_o           (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.out_byte;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.chunk_last;

endmodule

// ===== src/hcbd_core.sv =====
// Decoder state and per-byte decode step.
module hcbd_core import hcbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        in_byte_i,
  input  logic [LimitW-1:0] size_limit_i,
  input  logic [LimitW-1:0] trailer_limit_i,
  output hcbd_res_t         res_o
);

  typedef struct packed {
    logic              ok;
    phase_e            phase;
    logic [SizeW-1:0]  rem;
    logic [LimitW-1:0] cnt;
    logic              digit;
  } line_st_t;

  phase_e            phase_q, phase_d;
  logic [SizeW-1:0]  rem_q, rem_d;
  logic [LimitW-1:0] cnt_q, cnt_d;
  logic              digit_q, digit_d;
  logic              crp_q, crp_d;

  line_st_t s0, s1, s2, sc;

  // Map an ASCII hex digit to its value; valid flag in the top bit.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

  // Take one content byte of a line.
  function automatic line_st_t content(line_st_t s, logic [7:0] c,
                                       logic [LimitW-1:0] szlim,
                                       logic [LimitW-1:0] trlim);
    line_st_t          r;
    logic [LimitW-1:0] lim;
    logic [4:0]        hv;
    r   = s;
    lim = (s.phase == PH_TRAILER) ? trlim : szlim;
    hv  = hex_val(c);
    if (!s.ok) begin
      r.ok = 1'b0;
    end else if (({1'b0, s.cnt} + (LimitW+1)'(1)) > {1'b0, lim}) begin
      r.ok = 1'b0;
    end else begin
      r.cnt = s.cnt + LimitW'(1);
      case (s.phase)
        PH_SIZE: begin
          if (c == ByteSemi) begin
            r.phase = PH_EXT;
          end else if (!hv[4] || s.rem[SizeW-1:SizeW-4] != 4'd0) begin
            r.ok = 1'b0;
          end else begin
            r.rem   = {s.rem[SizeW-5:0], hv[3:0]};
            r.digit = 1'b1;
          end
        end
        PH_EXT, PH_TRAILER: r.ok = 1'b1;
        default: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Chain a held CR and the new byte through the line logic.
  assign s0 = '{ok: 1'b1, phase: phase_q, rem: rem_q, cnt: cnt_q, digit: digit_q};
  assign s1 = content(s0, ByteCr, size_limit_i, trailer_limit_i);
  assign sc = crp_q ? s1 : s0;
  assign s2 = content(sc, in_byte_i, size_limit_i, trailer_limit_i);

  // Next state and result of the current byte.
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    digit_d = digit_q;
    crp_d   = crp_q;
    res_o   = '{out_byte: 8'd0, kind: KIND_FRAME, chunk_last: 1'b0};
    case (phase_q)
      PH_DONE, PH_ERROR: begin
        res_o.kind = KIND_IGNORED;
      end
      PH_DATA: begin
        res_o.out_byte = in_byte_i;
        res_o.kind     = KIND_PAYLOAD;
        rem_d          = rem_q - SizeW'(1);
        if (rem_q == SizeW'(1)) begin
          res_o.chunk_last = 1'b1;
          phase_d          = PH_DATA_EOL;
          cnt_d            = '0;
          crp_d            = 1'b0;
        end
      end
      PH_SIZE, PH_EXT, PH_DATA_EOL, PH_TRAILER: begin
        if (in_byte_i == ByteLf) begin
          // End of line
          crp_d = 1'b0;
          cnt_d = '0;
          case (phase_q)
            PH_SIZE, PH_EXT: begin
              if (!digit_q) begin
                phase_d    = PH_ERROR;
                res_o.kind = KIND_ERROR;
              end else begin
                digit_d = 1'b0;
                phase_d = (rem_q == '0) ? PH_TRAILER : PH_DATA;
              end
            end
            PH_DATA_EOL: begin
              if (cnt_q != '0) begin
                phase_d    = PH_ERROR;
                res_o.kind = KIND_ERROR;
              end else begin
                phase_d = PH_SIZE;
                rem_d   = '0;
              end
            end
            default: begin
              if (cnt_q == '0) begin
                phase_d    = PH_DONE;
                res_o.kind = KIND_END;
              end
            end
          endcase
        end else if (crp_q && !s1.ok) begin
          phase_d    = PH_ERROR;
          res_o.kind = KIND_ERROR;
        end else if (in_byte_i == ByteCr) begin
          // Hold the CR until the next byte shows whether it ends the line
          crp_d   = 1'b1;
          phase_d = sc.phase;
          rem_d   = sc.rem;
          cnt_d   = sc.cnt;
          digit_d = sc.digit;
        end else if (!s2.ok) begin
          phase_d    = PH_ERROR;
          res_o.kind = KIND_ERROR;
        end else begin
          crp_d   = 1'b0;
          phase_d = s2.phase;
          rem_d   = s2.rem;
          cnt_d   = s2.cnt;
          digit_d = s2.digit;
        end
      end
      default: begin
        phase_d    = PH_ERROR;
        res_o.kind = KIND_ERROR;
      end
    endcase
  end

  // Advance the state on each decoded byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIZE;
      rem_q   <= '0;
      cnt_q   <= '0;
      digit_q <= 1'b0;
      crp_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      digit_q <= digit_d;
      crp_q   <= crp_d;
    end
  end

endmodule

// ===== src/hcbd_checker.sv =====
// Port checker for the chunked body decoder, bound to the top level.
module hcbd_checker import hcbd_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // Chunk end is only ever marked on a payload byte
  a_last_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tuser == KIND_PAYLOAD))
    else $error("tlast on a non-payload result");

  // Non-payload results carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_PAYLOAD) |-> (m_axis_tdata == 8'd0))
    else $error("non-payload result with nonzero data");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/sv/tb_top.sv =====
// Self-checking stream testbench for the HTTP chunked body decoder.
module tb_top;
  import hcbd_pkg::*;

  localparam int unsigned StallLimit = 4000;

  // How the body ends; one ending per run, as end and error both stick until reset.
  typedef enum int unsigned {
    END_OF_BODY,
    BAD_SIZE_BYTE,
    EMPTY_SIZE,
    SIZE_OVERFLOW,
    JUNK_AFTER_DATA,
    LINE_TOO_LONG
  } ending_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] out_byte
  logic [2:0]  m_axis_tuser;           // [2:0] kind
  logic        m_axis_tlast;           // chunk_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Pending body bytes and the decode results still owed by the block
  logic [7:0]  body_bytes[$];
  hcbd_res_t   due_results[$];

  // Predictor copy of the limits and the parser state
  logic [LimitW-1:0] lim_size = SizeLimitReset;
  logic [LimitW-1:0] lim_trailer = TrailerLimitReset;
  phase_e            ph = PH_SIZE;
  logic [SizeW-1:0]  rem = '0;
  logic [LimitW-1:0] lcount = '0;
  logic              seen = 1'b0;
  logic              cr_held = 1'b0;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          quiet = 1'b0;

  http_chunked_body_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones; none at all in a quiet stretch
  function automatic int unsigned draw_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (quiet || p < 70) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Account one content byte of a line; return 0 when it faults
  function automatic bit take_content(logic [7:0] c);
    logic [LimitW-1:0] lim;
    logic [3:0]        nib;
    lim = (ph == PH_TRAILER) ? lim_trailer : lim_size;
    if (32'(lcount) + 32'd1 > 32'(lim)) return 1'b0;
    lcount = lcount + 1'b1;
    case (ph)
      PH_SIZE: begin
        if (c == ByteSemi) begin
          ph = PH_EXT;
          return 1'b1;
        end
        if (c >= "0" && c <= "9") nib = 4'(c - "0");
        else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
        else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
        else return 1'b0;
        if (rem[SizeW-1 -: 4] != 4'h0) return 1'b0;
        rem  = {rem[SizeW-5:0], nib};
        seen = 1'b1;
        return 1'b1;
      end
      PH_EXT, PH_TRAILER: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Advance the parser by one accepted byte and return what it must report
  function automatic hcbd_res_t decode_byte(logic [7:0] b);
    hcbd_res_t r;
    bit        ok;
    bit        empty;
    r.out_byte   = 8'h00;
    r.kind       = KIND_FRAME;
    r.chunk_last = 1'b0;
    if (ph == PH_DONE || ph == PH_ERROR) begin
      r.kind = KIND_IGNORED;
    end else if (ph == PH_DATA) begin
      r.out_byte = b;
      r.kind     = KIND_PAYLOAD;
      rem        = rem - 1'b1;
      if (rem == '0) begin
        r.chunk_last = 1'b1;
        ph           = PH_DATA_EOL;
        lcount       = '0;
        cr_held      = 1'b0;
      end
    end else if (b == ByteLf) begin
      cr_held = 1'b0;
      empty   = (lcount == '0);
      lcount  = '0;
      case (ph)
        PH_SIZE, PH_EXT: begin
          if (!seen) begin
            ph     = PH_ERROR;
            r.kind = KIND_ERROR;
          end else begin
            seen = 1'b0;
            ph   = (rem == '0) ? PH_TRAILER : PH_DATA;
          end
        end
        PH_DATA_EOL: begin
          if (!empty) begin
            ph     = PH_ERROR;
            r.kind = KIND_ERROR;
          end else begin
            ph  = PH_SIZE;
            rem = '0;
          end
        end
        PH_TRAILER: begin
          if (empty) begin
            ph     = PH_DONE;
            r.kind = KIND_END;
          end
        end
        default: begin
          ph     = PH_ERROR;
          r.kind = KIND_ERROR;
        end
      endcase
    end else begin
      // A held CR not followed by LF turns into line content
      ok = 1'b1;
      if (cr_held) begin
        cr_held = 1'b0;
        ok      = take_content(ByteCr);
      end
      if (ok) begin
        if (b == ByteCr) cr_held = 1'b1;
        else ok = take_content(b);
      end
      if (!ok) begin
        ph     = PH_ERROR;
        r.kind = KIND_ERROR;
      end
    end
    return r;
  endfunction

  // Body stream driver: predict on each accepted request, then load the next byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) due_results.push_back(decode_byte(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (body_bytes.size() != 0) begin
          s_axis_tdata  <= body_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap      <= draw_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted request with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : result_mon
    hcbd_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_stall    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d, out_byte %0h", m_axis_tuser, m_axis_tdata);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (m_axis_tdata !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, m_axis_tuser);
            mismatches++;
          end
          if (m_axis_tlast !== want.chunk_last) begin
            $error("chunk_last: expected %0b, got %0b", want.chunk_last, m_axis_tlast);
            mismatches++;
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall    <= recv_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_stall    <= draw_gap();
      end
    end
  end

  // Stop a hung run: count cycles in which no request moves anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAIL http_chunked_body_decoder");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_access(input logic [2:0] addr, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] addr, input logic [LimitW-1:0] want);
    logic [31:0] rd;
    apb_access(addr, 1'b0, 32'd0, rd);
    if (rd !== 32'(want)) begin
      $error("register %0h readback: expected %0d, got %0d", addr, want, rd);
      mismatches++;
    end
  endtask

  task automatic set_limits(input logic [LimitW-1:0] sz, input logic [LimitW-1:0] tr);
    logic [31:0] rd;
    apb_access(AddrSizeLimit, 1'b1, 32'(sz), rd);
    lim_size = sz;
    apb_access(AddrTrailerLimit, 1'b1, 32'(tr), rd);
    lim_trailer = tr;
    check_reg(AddrSizeLimit, sz);
    check_reg(AddrTrailerLimit, tr);
  endtask

  // Hold until every byte is taken and every result has come back
  task automatic wait_drained();
    while (body_bytes.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) body_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + v;
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v - 8'd10;
  endfunction

  // Any byte but LF
  function automatic logic [7:0] ext_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == ByteLf);
    return b;
  endfunction

  task automatic add_eol();
    if ($urandom_range(0, 2) != 0) body_bytes.push_back(ByteCr);
    body_bytes.push_back(ByteLf);
  endtask

  // Size line within the size limit: leading zeros, mixed-case digits, optional extension
  task automatic add_size_line(input logic [SizeW-1:0] size, input int unsigned ext_max);
    int unsigned ndig;
    int unsigned room;
    int unsigned zeros;
    int unsigned extlen;
    ndig = 1;
    while (ndig < 16 && (size >> (4 * ndig)) != 0) ndig++;
    room  = (lim_size > ndig) ? lim_size - ndig : 0;
    zeros = $urandom_range(0, 3);
    if (room <= 64 && $urandom_range(0, 4) == 0) zeros = room;
    if (zeros > room) zeros = room;
    room = room - zeros;
    repeat (zeros) body_bytes.push_back("0");
    for (int i = ndig - 1; i >= 0; i--) body_bytes.push_back(hex_char(size[4 * i +: 4]));
    if (ext_max != 0 && room != 0 && $urandom_range(0, 2) == 0) begin
      extlen = $urandom_range(0, (room - 1 < ext_max) ? room - 1 : ext_max);
      body_bytes.push_back(ByteSemi);
      repeat (extlen) body_bytes.push_back(ext_byte());
    end
    add_eol();
  endtask

  // Well-formed chunks with random sizes and payload
  task automatic add_chunks(input int unsigned count, input int unsigned max_size,
                            input int unsigned ext_max);
    logic [SizeW-1:0] size;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       size = SizeW'(1);
        1:       size = SizeW'($urandom_range(17, max_size));
        default: size = SizeW'($urandom_range(1, 16));
      endcase
      if (lim_size == 1 && size > 15) size = SizeW'($urandom_range(1, 15));
      add_size_line(size, ext_max);
      repeat (size) body_bytes.push_back(8'($urandom));
      add_eol();
    end
  endtask

  initial begin : stimulus
    ending_e     ending;
    logic [7:0]  b;
    int unsigned n;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    check_reg(AddrSizeLimit, SizeLimitReset);
    check_reg(AddrTrailerLimit, TrailerLimitReset);

    // Extreme payload bytes, an extension, a CR that is extension content
    quiet = 1'b1;
    @(negedge clk_i);
    push_text("003;a=b\015\012");
    body_bytes.push_back(8'h00);
    body_bytes.push_back(8'hFF);
    body_bytes.push_back(ByteLf);
    push_text("\015\012");
    push_text("1;\015x\012");
    body_bytes.push_back(ByteCr);
    body_bytes.push_back(ByteLf);

    // Default limits, with a full pause in the middle of the body
    quiet = 1'b0;
    add_chunks(3, 64, 12);
    wait_drained();
    @(negedge clk_i);
    add_chunks(3, 64, 12);
    wait_drained();

    // Tightest limits: a single content byte per line
    set_limits(LimitW'(1), LimitW'(1));
    quiet = 1'($urandom_range(0, 1));
    @(negedge clk_i);
    add_chunks(6, 15, 0);
    wait_drained();

    // Widest limits, with longer extensions
    set_limits(LimitW'(65536), LimitW'(65536));
    quiet = 1'b0;
    @(negedge clk_i);
    add_chunks(4, 64, 60);
    wait_drained();

    // Closing stretch: random limits, then the chosen ending and some ignored bytes
    ending = ending_e'($urandom_range(0, 5));
    if (ending == LINE_TOO_LONG) begin
      set_limits(LimitW'($urandom_range(1, 16)), LimitW'($urandom_range(1, 16)));
    end else begin
      set_limits(LimitW'($urandom_range(24, 1024)), LimitW'($urandom_range(1, 65536)));
    end
    @(negedge clk_i);
    add_chunks(4, 64, 8);
    case (ending)
      END_OF_BODY: begin
        add_size_line('0, 8);
        repeat ($urandom_range(0, 3)) begin
          n = $urandom_range(1, (lim_trailer < 10) ? lim_trailer : 10);
          do b = 8'($urandom); while (b == ByteCr || b == ByteLf);
          body_bytes.push_back(b);
          repeat (n - 1) body_bytes.push_back(ext_byte());
          add_eol();
        end
        add_eol();
      end
      BAD_SIZE_BYTE: begin
        if ($urandom_range(0, 1)) body_bytes.push_back(hex_char(4'($urandom)));
        if ($urandom_range(0, 3) == 0) begin
          b = ByteCr;
        end else begin
          do b = 8'($urandom);
          while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f")
                 || b == ByteSemi || b == ByteLf);
        end
        body_bytes.push_back(b);
        if (b == ByteCr) body_bytes.push_back(hex_char(4'($urandom)));
        add_eol();
      end
      EMPTY_SIZE: begin
        if ($urandom_range(0, 1)) begin
          body_bytes.push_back(ByteSemi);
          repeat ($urandom_range(0, 6)) body_bytes.push_back(ext_byte());
        end
        add_eol();
      end
      SIZE_OVERFLOW: begin
        repeat ($urandom_range(0, 3)) body_bytes.push_back("0");
        body_bytes.push_back(hex_char(4'($urandom_range(1, 15))));
        repeat (16) body_bytes.push_back(hex_char(4'($urandom)));
        add_eol();
      end
      JUNK_AFTER_DATA: begin
        n = $urandom_range(1, 16);
        add_size_line(SizeW'(n), 4);
        repeat (n) body_bytes.push_back(8'($urandom));
        b = ($urandom_range(0, 3) == 0) ? ByteCr : ext_byte();
        body_bytes.push_back(b);
        if (b == ByteCr) body_bytes.push_back(ext_byte());
        add_eol();
      end
      default: begin
        if ($urandom_range(0, 1)) begin
          repeat (lim_size + 1) body_bytes.push_back("0");
        end else begin
          add_size_line('0, 0);
          repeat (lim_trailer + 1) body_bytes.push_back("x");
        end
        add_eol();
      end
    endcase
    repeat (8) body_bytes.push_back(8'($urandom));
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS http_chunked_body_decoder");
    end else begin
      $display("FAIL http_chunked_body_decoder");
    end
    $finish;
  end

endmodule
